/* src/tfs_pkg.sv */
// ----------------------------------------------------------------------------
// tfs_pkg
// Types and codes shared by the timed frame sequencer files.
// ----------------------------------------------------------------------------
`default_nettype none

package tfs_pkg;

    localparam int MODE_W     = 4;
    localparam int VALUE_W    = 16;
    localparam int TIDX_W     = 4;
    localparam int FRAME_O_W  = 4;
    localparam int FCOUNT_W   = 5;
    localparam int HOLD_W     = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [MODE_W-1:0] {
        MODE_TICK         = 4'd0,
        MODE_PLAY         = 4'd1,
        MODE_STOP         = 4'd2,
        MODE_FREEZE       = 4'd3,
        MODE_REWIND       = 4'd4,
        MODE_SET_FRAME    = 4'd5,
        MODE_SET_HOLD     = 4'd6,
        MODE_CLEAR_EFFECT = 4'd7,
        MODE_LOAD_TABLE   = 4'd8
    } t_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_COUNT     = 3'd0,
        CFG_DEFAULT_HOLD    = 3'd1,
        CFG_USE_HOLD_TABLE  = 3'd2,
        CFG_LOOP_ENABLE     = 3'd3,
        CFG_PLAY_REVERSE    = 3'd4
    } t_cfg_index;

    typedef struct packed {
        logic [FCOUNT_W-1:0] frame_count;
        logic [HOLD_W-1:0]   default_hold_ms;
        logic                use_hold_table;
        logic                loop_enable;
        logic                play_reverse;
    } t_cfg;

    typedef struct packed {
        logic [FRAME_O_W-1:0] frame_index;
        logic                 advanced;
        logic                 is_finished;
        logic                 is_frozen;
        logic                 effect_pending;
    } t_result;

endpackage

`default_nettype wire

/* src/tfs_in_if.sv */
// ----------------------------------------------------------------------------
// tfs_in_if
// Item channel: mode, value and table index with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface tfs_in_if;
    logic                         valid;
    logic                         ready;
    logic [tfs_pkg::MODE_W-1:0]   mode;
    logic [tfs_pkg::VALUE_W-1:0]  value;
    logic [tfs_pkg::TIDX_W-1:0]   table_index;

    modport source (output valid, output mode, output value, output table_index,
                    input ready);
    modport sink   (input valid, input mode, input value, input table_index,
                    output ready);
endinterface

`default_nettype wire

/* src/tfs_out_if.sv */
// ----------------------------------------------------------------------------
// tfs_out_if
// Result channel: frame index and status flags with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface tfs_out_if;
    logic                            valid;
    logic                            ready;
    logic [tfs_pkg::FRAME_O_W-1:0]   frame_index;
    logic                            advanced;
    logic                            is_finished;
    logic                            is_frozen;
    logic                            effect_pending;

    modport source (output valid, output frame_index, output advanced,
                    output is_finished, output is_frozen, output effect_pending,
                    input ready);
    modport sink   (input valid, input frame_index, input advanced,
                    input is_finished, input is_frozen, input effect_pending,
                    output ready);
endinterface

`default_nettype wire

/* src/tfs_ram.sv */
// ----------------------------------------------------------------------------
// tfs_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module tfs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

/* src/tfs_engine.sv */
// ----------------------------------------------------------------------------
// tfs_engine
// Sequencer state, hold table and the per-item update logic.
// ----------------------------------------------------------------------------
`default_nettype none

module tfs_engine #(
    parameter int MAX_FRAMES = 16,
    parameter int TIME_BITS  = 16
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_accept,
    input  wire logic [tfs_pkg::MODE_W-1:0]     i_mode,
    input  wire logic [tfs_pkg::VALUE_W-1:0]    i_value,
    input  wire logic [tfs_pkg::TIDX_W-1:0]     i_table_index,
    input  wire tfs_pkg::t_cfg                  i_cfg,
    output tfs_pkg::t_result                    o_result
);

    localparam int FW      = $clog2(MAX_FRAMES);
    localparam int CW      = ((FW > tfs_pkg::FCOUNT_W) ? FW : tfs_pkg::FCOUNT_W) + 1;
    localparam int LW      = (TIME_BITS > tfs_pkg::HOLD_W) ? TIME_BITS : tfs_pkg::HOLD_W;
    localparam int CNT_CAP = (MAX_FRAMES < 31) ? MAX_FRAMES : 31;

    logic [FW-1:0]             r_frame, n_frame;
    logic [TIME_BITS-1:0]      r_elapsed, n_elapsed;
    logic                      r_finished, n_finished;
    logic                      r_frozen, n_frozen;
    logic                      r_effect, n_effect;
    logic                      r_ovr_valid, n_ovr_valid;
    logic [tfs_pkg::HOLD_W-1:0] r_ovr_hold, n_ovr_hold;
    logic                      r_fwd_hit;
    logic [tfs_pkg::HOLD_W-1:0] r_fwd_data;

    logic [tfs_pkg::FCOUNT_W-1:0] count;
    logic [FW-1:0]                last_frame;
    logic [tfs_pkg::HOLD_W-1:0]   ram_data;
    logic [tfs_pkg::HOLD_W-1:0]   table_hold;
    logic [tfs_pkg::HOLD_W-1:0]   limit;
    logic [TIME_BITS-1:0]         elapsed_inc;
    logic [CW-1:0]                frame_x;
    logic [CW-1:0]                count_x;
    logic [CW-1:0]                next_up;
    logic                         step;
    logic                         adv;
    logic                         tbl_we;
    logic [FW-1:0]                tbl_addr;
    logic [FW-1:0]                rd_addr;
    tfs_pkg::t_mode               mode;

    // active frame count: zero acts as one, clamp at the table depth or 31, whichever is less
    always_comb begin
        if (i_cfg.frame_count == '0) begin
            count = tfs_pkg::FCOUNT_W'(1);
        end else if (32'(i_cfg.frame_count) > CNT_CAP) begin
            count = tfs_pkg::FCOUNT_W'(CNT_CAP);
        end else begin
            count = i_cfg.frame_count;
        end
    end

    assign last_frame  = FW'(count - tfs_pkg::FCOUNT_W'(1));
    assign mode        = tfs_pkg::t_mode'(i_mode);
    assign table_hold  = r_fwd_hit ? r_fwd_data : ram_data;
    assign elapsed_inc = (r_elapsed == '1) ? r_elapsed : r_elapsed + TIME_BITS'(1);
    assign frame_x     = CW'(r_frame);
    assign count_x     = CW'(count);
    assign step        = ~r_frozen;
    assign next_up     = frame_x + CW'(step);

    always_comb begin
        if (r_ovr_valid) begin
            limit = r_ovr_hold;
        end else if (i_cfg.use_hold_table) begin
            limit = table_hold;
        end else begin
            limit = i_cfg.default_hold_ms;
        end
    end

    assign tbl_we   = i_accept && (mode == tfs_pkg::MODE_LOAD_TABLE)
                      && (32'(i_table_index) < MAX_FRAMES);
    assign tbl_addr = FW'(i_table_index);

    always_comb begin
        n_frame     = r_frame;
        n_elapsed   = r_elapsed;
        n_finished  = r_finished;
        n_frozen    = r_frozen;
        n_effect    = r_effect;
        n_ovr_valid = r_ovr_valid;
        n_ovr_hold  = r_ovr_hold;
        adv         = 1'b0;
        if (i_accept) begin
            unique case (mode)
                tfs_pkg::MODE_TICK: begin
                    if (!r_finished) begin
                        if (LW'(elapsed_inc) > LW'(limit)) begin
                            adv         = 1'b1;
                            n_ovr_valid = 1'b0;
                            n_elapsed   = '0;
                            n_effect    = 1'b1;
                            if (i_cfg.play_reverse) begin
                                if (frame_x >= count_x) begin
                                    n_frame    = '0;
                                    n_finished = r_finished | ~i_cfg.loop_enable;
                                end else if (step && (r_frame == '0)) begin
                                    n_frame    = last_frame;
                                    n_finished = r_finished | ~i_cfg.loop_enable;
                                end else begin
                                    n_frame = r_frame - FW'(step);
                                end
                            end else begin
                                if (next_up >= count_x) begin
                                    n_frame    = '0;
                                    n_finished = r_finished | ~i_cfg.loop_enable;
                                end else begin
                                    n_frame = FW'(next_up);
                                end
                            end
                        end else begin
                            n_elapsed = elapsed_inc;
                        end
                    end
                end
                tfs_pkg::MODE_PLAY: begin
                    n_finished = 1'b0;
                    n_frozen   = 1'b0;
                    n_elapsed  = '0;
                end
                tfs_pkg::MODE_STOP:         n_finished = 1'b1;
                tfs_pkg::MODE_FREEZE:       n_frozen   = 1'b1;
                tfs_pkg::MODE_REWIND: begin
                    n_frame = i_cfg.play_reverse ? last_frame : '0;
                end
                tfs_pkg::MODE_SET_FRAME: begin
                    if (i_value >= tfs_pkg::VALUE_W'(count)) begin
                        n_frame = last_frame;
                    end else begin
                        n_frame = FW'(i_value);
                    end
                end
                tfs_pkg::MODE_SET_HOLD: begin
                    n_ovr_hold  = i_value;
                    n_ovr_valid = 1'b1;
                end
                tfs_pkg::MODE_CLEAR_EFFECT: n_effect = 1'b0;
                tfs_pkg::MODE_LOAD_TABLE:   ;
                default:                    ;
            endcase
        end
    end

    // table read follows the frame the next item will see
    assign rd_addr = i_rst_n ? n_frame : '0;

    tfs_ram #(
        .WIDTH (tfs_pkg::HOLD_W),
        .DEPTH (MAX_FRAMES)
    ) u_hold_ram (
        .i_clk     (i_clk),
        .i_we      (tbl_we),
        .i_wr_addr (tbl_addr),
        .i_wr_data (i_value),
        .i_rd_addr (rd_addr),
        .o_rd_data (ram_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame     <= '0;
            r_elapsed   <= '0;
            r_finished  <= 1'b1;
            r_frozen    <= 1'b0;
            r_effect    <= 1'b0;
            r_ovr_valid <= 1'b0;
            r_ovr_hold  <= '0;
            r_fwd_hit   <= 1'b0;
        end else begin
            r_frame     <= n_frame;
            r_elapsed   <= n_elapsed;
            r_finished  <= n_finished;
            r_frozen    <= n_frozen;
            r_effect    <= n_effect;
            r_ovr_valid <= n_ovr_valid;
            r_ovr_hold  <= n_ovr_hold;
            r_fwd_hit   <= tbl_we && (tbl_addr == rd_addr);
        end
        r_fwd_data <= i_value;
    end

    assign o_result.frame_index    = tfs_pkg::FRAME_O_W'(n_frame);
    assign o_result.advanced       = adv;
    assign o_result.is_finished    = n_finished;
    assign o_result.is_frozen      = n_frozen;
    assign o_result.effect_pending = n_effect;

endmodule

`default_nettype wire

/* src/timed_frame_sequencer.sv */
// ----------------------------------------------------------------------------
// timed_frame_sequencer
// Millisecond-tick frame sequencer with per-frame hold table and commands.
//
//   channel   dir   payload                              transfer when
//   i_item    in    mode, value, table_index             valid & ready
//   o_result  out   frame_index, advanced, flags         valid & ready
//   i_cfg_*   in    register index, data                 i_cfg_we
//
// one item per cycle while ready is high; the result appears in the output
// register in the cycle after its transfer. the hold table read is registered
// and addressed by the next frame, with a bypass for a table write to that
// frame. reset clears all control state and sets the finished flag. ready
// drops only while a held result is not taken.
// ----------------------------------------------------------------------------
`default_nettype none

module timed_frame_sequencer #(
    parameter int MAX_FRAMES = 16,
    parameter int TIME_BITS  = 16
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [tfs_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [tfs_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    tfs_in_if.sink                                 i_item,
    tfs_out_if.source                              o_result
);

    tfs_pkg::t_cfg    r_cfg;
    tfs_pkg::t_result r_result;
    tfs_pkg::t_result step_result;
    logic             r_out_valid;
    logic             accept;

    assign i_item.ready = ~r_out_valid | o_result.ready;
    assign accept       = i_item.valid & i_item.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.frame_count     <= tfs_pkg::FCOUNT_W'(1);
            r_cfg.default_hold_ms <= '0;
            r_cfg.use_hold_table  <= 1'b0;
            r_cfg.loop_enable     <= 1'b0;
            r_cfg.play_reverse    <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (tfs_pkg::t_cfg_index'(i_cfg_index))
                tfs_pkg::CFG_FRAME_COUNT:
                    r_cfg.frame_count <= i_cfg_data[tfs_pkg::FCOUNT_W-1:0];
                tfs_pkg::CFG_DEFAULT_HOLD:
                    r_cfg.default_hold_ms <= i_cfg_data[tfs_pkg::HOLD_W-1:0];
                tfs_pkg::CFG_USE_HOLD_TABLE: r_cfg.use_hold_table <= i_cfg_data[0];
                tfs_pkg::CFG_LOOP_ENABLE:    r_cfg.loop_enable    <= i_cfg_data[0];
                tfs_pkg::CFG_PLAY_REVERSE:   r_cfg.play_reverse   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    tfs_engine #(
        .MAX_FRAMES (MAX_FRAMES),
        .TIME_BITS  (TIME_BITS)
    ) u_engine (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_mode        (i_item.mode),
        .i_value       (i_item.value),
        .i_table_index (i_item.table_index),
        .i_cfg         (r_cfg),
        .o_result      (step_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
        if (accept) begin
            r_result <= step_result;
        end
    end

    assign o_result.valid          = r_out_valid;
    assign o_result.frame_index    = r_result.frame_index;
    assign o_result.advanced       = r_result.advanced;
    assign o_result.is_finished    = r_result.is_finished;
    assign o_result.is_frozen      = r_result.is_frozen;
    assign o_result.effect_pending = r_result.effect_pending;

endmodule

`default_nettype wire
